// File: design/scpp_pkg.sv
// Shared constants for the S-curve position profile.
package scpp_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [1:0] REG_PEAK_ACCEL    = 2'd0;
    localparam logic [1:0] REG_SPEED_LIMIT   = 2'd1;
    localparam logic [1:0] REG_MOVE_DISTANCE = 2'd2;

    localparam logic [1:0] PH_ACCEL  = 2'd0;
    localparam logic [1:0] PH_CRUISE = 2'd1;
    localparam logic [1:0] PH_DECEL  = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

endpackage

// File: design/scpp_mul2.sv
// Two-stage pipelined multiplier with sideband, split into two partial products.
module scpp_mul2 #(
    parameter int AW  = 32,
    parameter int BW  = 32,
    parameter int SBW = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [AW-1:0]      i_a,
    input  logic [BW-1:0]      i_b,
    input  logic [SBW-1:0]     i_sb,
    output logic               o_valid,
    output logic [AW+BW-1:0]   o_p,
    output logic [SBW-1:0]     o_sb
);
    localparam int H  = BW / 2;
    localparam int HW = BW - H;

    logic [AW+H-1:0]  r_pl;
    logic [AW+HW-1:0] r_ph;
    logic [SBW-1:0]   r_sb1;
    logic             r_v1;
    logic [AW+BW-1:0] r_p;
    logic [SBW-1:0]   r_sb2;
    logic             r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pl  <= i_a * i_b[H-1:0];
            r_ph  <= i_a * i_b[BW-1:H];
            r_sb1 <= i_sb;
            r_p   <= {{HW{1'b0}}, r_pl} + {r_ph, {H{1'b0}}};
            r_sb2 <= r_sb1;
        end
    end

    assign o_valid = r_v2;
    assign o_p     = r_p;
    assign o_sb    = r_sb2;
endmodule

// File: design/scpp_div_pipe.sv
// Pipelined restoring divider: (x << W) / d, one quotient bit per stage.
module scpp_div_pipe #(
    parameter int W   = 32,
    parameter int SBW = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [W-1:0]   i_x,
    input  logic [W-1:0]   i_d,
    input  logic [SBW-1:0] i_sb,
    output logic           o_valid,
    output logic [W-1:0]   o_q,
    output logic [SBW-1:0] o_sb
);
    logic [W-1:0]   r_rem [W];
    logic [W-1:0]   r_q   [W];
    logic [SBW-1:0] r_sb  [W];
    logic [W-1:0]   r_v;

    logic [W-1:0]   w_rem_in [W];
    logic [W-1:0]   w_q_in   [W];
    logic [SBW-1:0] w_sb_in  [W];
    logic [W-1:0]   w_v_in;

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [W:0] rem2;
        logic [W:0] diff;
        logic       ge;

        if (k == 0) begin : g_first
            assign w_rem_in[k] = i_x;
            assign w_q_in[k]   = '0;
            assign w_sb_in[k]  = i_sb;
            assign w_v_in[k]   = i_valid;
        end else begin : g_next
            assign w_rem_in[k] = r_rem[k-1];
            assign w_q_in[k]   = r_q[k-1];
            assign w_sb_in[k]  = r_sb[k-1];
            assign w_v_in[k]   = r_v[k-1];
        end

        assign rem2 = {w_rem_in[k], 1'b0};
        assign diff = rem2 - {1'b0, i_d};
        assign ge   = (rem2 >= {1'b0, i_d});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v_in[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff[W-1:0] : rem2[W-1:0];
                r_q[k]   <= {w_q_in[k][W-2:0], ge};
                r_sb[k]  <= w_sb_in[k];
            end
        end
    end

    assign o_valid = r_v[W-1];
    assign o_q     = r_q[W-1];
    assign o_sb    = r_sb[W-1];
endmodule

// File: design/s_curve_position_profile.sv
// Top level of the S-curve position profile: set-up sequencer and sample pipeline.
//
// Usage: write peak_accel, speed_limit and move_distance over the APB port
// (registers at byte addresses 0, 4, 8; 0, 8, 16 when DATA_WIDTH > 32).
// Each write to one of these registers, and reset, starts a set-up pass
// (iterative multiply, divide and square root, one bit per cycle); o_stall
// stays high on the input channel until it ends. After that every time
// sample item on i_sample_time yields one result item: position, phase,
// total time and the speed-limited flag.
// Throughput: one item per cycle while the receiver does not stall. The
// pipeline holds the divider pipeline (one quotient bit per stage) and five
// two-stage multipliers in series.
// Reset is synchronous, active low: registers return to 1.0, the pipeline
// empties and the set-up pass runs. When the receiver stalls while a result
// waits, the whole pipeline holds and o_stall is raised to the sender; nothing is lost.
module s_curve_position_profile
    import scpp_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int PW        = (DATA_WIDTH > 32) ? 64 : 32,
    localparam int AWD       = (DATA_WIDTH > 32) ? 5 : 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [AWD-1:0]        paddr,
    input  logic [PW-1:0]         pwdata,
    output logic [PW-1:0]         prdata,
    output logic                  pready,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [DATA_WIDTH-1:0] i_sample_time,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [DATA_WIDTH-1:0] o_position,
    output logic [1:0]            o_phase,
    output logic [DATA_WIDTH-1:0] o_total_time,
    output logic                  o_speed_limited
);
    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int NW = 2 * W + 2;
    localparam int CW = $clog2(NW + 1);
    localparam int SH = AWD - 2;
    localparam int SUMW = 2 * W - F + 1;

    typedef enum logic [3:0] {
        ST_START, ST_MSM, ST_D3, ST_SQ, ST_PICK, ST_MVV,
        ST_DL, ST_DRD, ST_CR, ST_DCD, ST_FIN, ST_IDLE
    } t_setup_state;

    // configuration
    logic [W-1:0] r_pa, r_sl, r_md;
    logic [1:0]   cfg_idx;
    logic         cfg_wr;

    // set-up state
    t_setup_state r_st;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [W+1:0]  r_den;
    logic [W+2:0]  r_rem;
    logic [W+1:0]  r_ma;
    logic [W:0]    r_root;

    // derived constants
    logic [W-1:0]  r_v, r_L, r_rd, r_cd, r_total;
    logic          r_lim;
    logic [W:0]    r_po, r_rdcd;
    logic [W+1:0]  r_end;

    assign cfg_idx = paddr[AWD-1:SH];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_comb begin
        case (cfg_idx)
            REG_PEAK_ACCEL:    prdata = PW'(r_pa);
            REG_SPEED_LIMIT:   prdata = PW'(r_sl);
            REG_MOVE_DISTANCE: prdata = PW'(r_md);
            default:           prdata = '0;
        endcase
    end

    logic [W-1:0]  m_eff, vreq;
    logic [W+2:0]  msum;
    logic [W+2:0]  drem2, ddiff;
    logic          dge;
    logic [W+3:0]  srem2, strial, sdiff;
    logic          sge;
    logic [W-1:0]  qsat;
    logic          p_lim;
    logic [W-1:0]  p_v;
    logic [W+1:0]  v3_pick, v3_cur;
    logic          c_zero;
    logic [W-1:0]  cdist;
    logic [W+1:0]  f_end;

    assign m_eff  = (r_pa == '0) ? {{(W-1){1'b0}}, 1'b1} : r_pa;
    assign vreq   = (r_sl == '0) ? {{(W-1){1'b0}}, 1'b1} : r_sl;
    assign msum   = {1'b0, r_num[NW-1:W]} + (r_num[0] ? {1'b0, r_ma} : '0);
    assign drem2  = {r_rem[W+1:0], r_num[NW-1]};
    assign ddiff  = drem2 - {1'b0, r_den};
    assign dge    = (drem2 >= {1'b0, r_den});
    assign srem2  = {r_rem[W+1:0], r_num[NW-1:NW-2]};
    assign strial = {1'b0, r_root, 2'b01};
    assign sdiff  = srem2 - strial;
    assign sge    = (srem2 >= strial);
    assign qsat   = (|r_num[NW-1:W]) ? '1 : r_num[W-1:0];
    assign p_lim  = (r_root < {1'b0, vreq});
    assign p_v    = p_lim ? r_root[W-1:0] : vreq;
    assign v3_pick = {2'b0, p_v} + {1'b0, p_v, 1'b0};
    assign v3_cur  = {2'b0, r_v} + {1'b0, r_v, 1'b0};
    assign c_zero = r_lim || ({r_L, 1'b0} > {1'b0, r_md});
    assign cdist  = c_zero ? '0 : (r_md - {r_L[W-2:0], 1'b0});
    assign f_end  = {1'b0, r_rd, 1'b0} + {2'b0, r_cd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pa <= W'(1) << F;
            r_sl <= W'(1) << F;
            r_md <= W'(1) << F;
            r_st <= ST_START;
        end else if (cfg_wr && (cfg_idx == REG_PEAK_ACCEL || cfg_idx == REG_SPEED_LIMIT
                                || cfg_idx == REG_MOVE_DISTANCE)) begin
            case (cfg_idx)
                REG_PEAK_ACCEL:  r_pa <= pwdata[W-1:0];
                REG_SPEED_LIMIT: r_sl <= pwdata[W-1:0];
                default:         r_md <= pwdata[W-1:0];
            endcase
            r_st <= ST_START;
        end else begin
            case (r_st)
                ST_START: begin
                    r_num <= {{(W+2){1'b0}}, r_md};
                    r_ma  <= {2'b0, m_eff};
                    r_cnt <= CW'(W);
                    r_st  <= ST_MSM;
                end
                ST_MSM: begin
                    if (r_cnt != '0) begin
                        r_num <= {msum, r_num[W-1:1]};
                        r_cnt <= r_cnt - 1'b1;
                    end else begin
                        r_num <= {r_num[NW-2:0], 1'b0};
                        r_den <= (W+2)'(3);
                        r_rem <= '0;
                        r_cnt <= CW'(NW);
                        r_st  <= ST_D3;
                    end
                end
                ST_D3: begin
                    if (r_cnt != '0) begin
                        r_rem <= dge ? ddiff : drem2;
                        r_num <= {r_num[NW-2:0], dge};
                        r_cnt <= r_cnt - 1'b1;
                    end else begin
                        r_rem  <= '0;
                        r_root <= '0;
                        r_cnt  <= CW'(W + 1);
                        r_st   <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    if (r_cnt != '0) begin
                        r_rem  <= sge ? sdiff[W+2:0] : srem2[W+2:0];
                        r_root <= {r_root[W-1:0], sge};
                        r_num  <= {r_num[NW-3:0], 2'b00};
                        r_cnt  <= r_cnt - 1'b1;
                    end else begin
                        r_st <= ST_PICK;
                    end
                end
                ST_PICK: begin
                    r_v   <= p_v;
                    r_lim <= p_lim;
                    r_ma  <= v3_pick;
                    r_num <= {{(W+2){1'b0}}, p_v};
                    r_cnt <= CW'(W);
                    r_st  <= ST_MVV;
                end
                ST_MVV: begin
                    if (r_cnt != '0) begin
                        r_num <= {msum, r_num[W-1:1]};
                        r_cnt <= r_cnt - 1'b1;
                    end else begin
                        r_den <= {m_eff, 2'b00};
                        r_rem <= '0;
                        r_cnt <= CW'(NW);
                        r_st  <= ST_DL;
                    end
                end
                ST_DL: begin
                    if (r_cnt != '0) begin
                        r_rem <= dge ? ddiff : drem2;
                        r_num <= {r_num[NW-2:0], dge};
                        r_cnt <= r_cnt - 1'b1;
                    end else begin
                        r_L   <= qsat;
                        r_num <= NW'(v3_cur) << F;
                        r_den <= {1'b0, m_eff, 1'b0};
                        r_rem <= '0;
                        r_cnt <= CW'(NW);
                        r_st  <= ST_DRD;
                    end
                end
                ST_DRD: begin
                    if (r_cnt != '0) begin
                        r_rem <= dge ? ddiff : drem2;
                        r_num <= {r_num[NW-2:0], dge};
                        r_cnt <= r_cnt - 1'b1;
                    end else begin
                        r_rd <= qsat;
                        r_st <= ST_CR;
                    end
                end
                ST_CR: begin
                    r_po <= {1'b0, r_L} + {1'b0, cdist};
                    if (r_lim || r_v == '0) begin
                        r_cd <= '0;
                        r_st <= ST_FIN;
                    end else begin
                        r_num <= NW'(cdist) << F;
                        r_den <= {2'b0, r_v};
                        r_rem <= '0;
                        r_cnt <= CW'(NW);
                        r_st  <= ST_DCD;
                    end
                end
                ST_DCD: begin
                    if (r_cnt != '0) begin
                        r_rem <= dge ? ddiff : drem2;
                        r_num <= {r_num[NW-2:0], dge};
                        r_cnt <= r_cnt - 1'b1;
                    end else begin
                        r_cd <= qsat;
                        r_st <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_rdcd  <= {1'b0, r_rd} + {1'b0, r_cd};
                    r_end   <= f_end;
                    r_total <= (|f_end[W+1:W]) ? '1 : f_end[W-1:0];
                    r_st    <= ST_IDLE;
                end
                ST_IDLE: r_st <= ST_IDLE;
                default: r_st <= ST_START;
            endcase
        end
    end

    // sample pipeline
    logic adv, busy;
    logic r7_v;
    assign busy    = (r_st != ST_IDLE);
    assign adv     = !r7_v || !i_stall;
    assign o_stall = !adv || busy;

    logic         r1_v;
    logic [W-1:0] r1_t;
    logic         r2_v, r2_full;
    logic [1:0]   r2_ph;
    logic [W-1:0] r2_x, r2_t2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (adv) begin
            r1_v <= i_valid && !busy;
            r2_v <= r1_v;
        end
    end

    logic [W+1:0] x_full_w;
    assign x_full_w = r_end - {2'b0, r1_t};

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_t    <= i_sample_time;
            r2_t2   <= r1_t - r_rd;
            r2_full <= ({1'b0, r1_t} == r_rdcd);
            if (r1_t < r_rd) begin
                r2_ph <= PH_ACCEL;
                r2_x  <= r1_t;
            end else begin
                r2_x <= x_full_w[W-1:0];
                if ({1'b0, r1_t} < r_rdcd) begin
                    r2_ph <= PH_CRUISE;
                end else if ({2'b0, r1_t} < r_end) begin
                    r2_ph <= PH_DECEL;
                end else begin
                    r2_ph <= PH_DONE;
                end
            end
        end
    end

    logic           mc_v;
    logic [2*W-1:0] mc_p;
    logic [1:0]     mc_ph;
    logic [W-1:0]   mc_x;
    logic           mc_full;

    scpp_mul2 #(.AW(W), .BW(W), .SBW(W + 3)) u_mul_cruise (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_valid(r2_v),
        .i_a(r_v), .i_b(r2_t2), .i_sb({r2_ph, r2_x, r2_full}),
        .o_valid(mc_v), .o_p(mc_p), .o_sb({mc_ph, mc_x, mc_full})
    );

    logic [SUMW-1:0] csum;
    assign csum = SUMW'(r_L) + SUMW'(mc_p[2*W-1:F]);

    logic         r5_v, r5_full;
    logic [1:0]   r5_ph;
    logic [W-1:0] r5_x, r5_pc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (adv) begin
            r5_v <= mc_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_ph   <= mc_ph;
            r5_x    <= mc_x;
            r5_full <= mc_full;
            r5_pc   <= (|csum[SUMW-1:W]) ? '1 : csum[W-1:0];
        end
    end

    logic         d_v, d_full;
    logic [W-1:0] d_u, d_pc;
    logic [1:0]   d_ph;

    scpp_div_pipe #(.W(W), .SBW(W + 3)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_valid(r5_v),
        .i_x(r5_x), .i_d(r_rd), .i_sb({r5_ph, r5_full, r5_pc}),
        .o_valid(d_v), .o_q(d_u), .o_sb({d_ph, d_full, d_pc})
    );

    logic           m1_v, m1_full;
    logic [2*W-1:0] m1_p;
    logic [1:0]     m1_ph;
    logic [W-1:0]   m1_pc, m1_u;

    scpp_mul2 #(.AW(W), .BW(W), .SBW(2 * W + 3)) u_mul_u2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_valid(d_v),
        .i_a(d_u), .i_b(d_u), .i_sb({d_ph, d_full, d_pc, d_u}),
        .o_valid(m1_v), .o_p(m1_p), .o_sb({m1_ph, m1_full, m1_pc, m1_u})
    );

    logic           m2_v, m2_full;
    logic [2*W-1:0] m2_p;
    logic [1:0]     m2_ph;
    logic [W-1:0]   m2_pc, m2_u;

    scpp_mul2 #(.AW(W), .BW(W), .SBW(2 * W + 3)) u_mul_u3 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_valid(m1_v),
        .i_a(m1_p[2*W-1:W]), .i_b(m1_u), .i_sb({m1_ph, m1_full, m1_pc, m1_u}),
        .o_valid(m2_v), .o_p(m2_p), .o_sb({m2_ph, m2_full, m2_pc, m2_u})
    );

    logic           m3_v, m3_full;
    logic [2*W-1:0] m3_p;
    logic [1:0]     m3_ph;
    logic [W-1:0]   m3_pc, m3_u3;

    scpp_mul2 #(.AW(W), .BW(W), .SBW(2 * W + 3)) u_mul_u4 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_valid(m2_v),
        .i_a(m2_p[2*W-1:W]), .i_b(m2_u),
        .i_sb({m2_ph, m2_full, m2_pc, m2_p[2*W-1:W]}),
        .o_valid(m3_v), .o_p(m3_p), .o_sb({m3_ph, m3_full, m3_pc, m3_u3})
    );

    logic         r6_v, r6_full, r6_neg;
    logic [1:0]   r6_ph;
    logic [W-1:0] r6_pc;
    logic [W:0]   r6_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (adv) begin
            r6_v <= m3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_ph   <= m3_ph;
            r6_full <= m3_full;
            r6_pc   <= m3_pc;
            r6_neg  <= ({1'b0, m3_p[2*W-1:W]} > {m3_u3, 1'b0});
            r6_d    <= {m3_u3, 1'b0} - {1'b0, m3_p[2*W-1:W]};
        end
    end

    logic           m4_v, m4_full, m4_neg;
    logic [2*W:0]   m4_p;
    logic [1:0]     m4_ph;
    logic [W-1:0]   m4_pc;

    scpp_mul2 #(.AW(W), .BW(W + 1), .SBW(W + 4)) u_mul_ramp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_valid(r6_v),
        .i_a(r_L), .i_b(r6_d), .i_sb({r6_ph, r6_full, r6_neg, r6_pc}),
        .o_valid(m4_v), .o_p(m4_p), .o_sb({m4_ph, m4_full, m4_neg, m4_pc})
    );

    logic [W:0]   ramp;
    logic [W-1:0] p_ramp, pe;
    logic [W+1:0] dsum;

    assign ramp = m4_p[2*W:W];

    always_comb begin
        if (m4_full) begin
            p_ramp = r_L;
        end else if (m4_neg) begin
            p_ramp = '0;
        end else if (ramp > {1'b0, r_L}) begin
            p_ramp = r_L;
        end else begin
            p_ramp = ramp[W-1:0];
        end
        case (m4_ph)
            PH_DECEL: pe = r_L - p_ramp;
            PH_DONE:  pe = r_L;
            default:  pe = '0;
        endcase
    end

    assign dsum = {1'b0, r_po} + {2'b0, pe};

    logic [W-1:0] r7_pos;
    logic [1:0]   r7_ph;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (adv) begin
            r7_v <= m4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r7_ph <= m4_ph;
            case (m4_ph)
                PH_ACCEL:  r7_pos <= p_ramp;
                PH_CRUISE: r7_pos <= m4_pc;
                default:   r7_pos <= (|dsum[W+1:W]) ? '1 : dsum[W-1:0];
            endcase
        end
    end

    assign o_valid         = r7_v;
    assign o_position      = r7_pos;
    assign o_phase         = r7_ph;
    assign o_total_time    = r_total;
    assign o_speed_limited = r_lim;
endmodule

// File: tb/sv/s_curve_position_profile_chk.sv
// Checker for the S-curve position profile: watches both channels and the APB port, predicts, compares.
module s_curve_position_profile_chk
    import scpp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        i_valid,
    input  logic        o_stall,
    input  logic [31:0] i_sample_time,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [31:0] o_position,
    input  logic [1:0]  o_phase,
    input  logic [31:0] o_total_time,
    input  logic        o_speed_limited,
    output int          fail_count,
    output int          pending,
    output logic [31:0] ramp_time,
    output logic [31:0] cruise_time
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [127:0] wide_t;
    typedef struct packed {
        logic [31:0] position;
        logic [1:0]  phase;
        logic [31:0] total_time;
        logic        speed_limited;
    } profile_t;

    logic [31:0] accel_reg, speed_reg, dist_reg;
    wide_t ramp_len, cubic_coeff, cruise_dist, speed_v, ramp_dur, cruise_dur, decel_start;
    logic  limited;
    profile_t profile_q[$];

    function automatic logic [31:0] sat32(wide_t a);
        return (a > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : a[31:0];
    endfunction

    function automatic wide_t floor_sqrt(wide_t x);
        wide_t r;
        wide_t trial;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            trial = r | (wide_t'(1) << i);
            if (trial * trial <= x) r = trial;
        end
        return r;
    endfunction

    task automatic derive_profile();
        wide_t m, vreq, s, vlim;
        m    = (accel_reg == 0) ? 1 : accel_reg;
        vreq = (speed_reg == 0) ? 1 : speed_reg;
        s    = dist_reg;
        vlim = floor_sqrt((s * m * 2) / 3);
        limited = vlim < vreq;
        speed_v = limited ? vlim : vreq;
        ramp_len = sat32((3 * speed_v * speed_v) / (4 * m));
        ramp_dur = sat32((3 * speed_v * 65536) / (2 * m));
        cubic_coeff = 2 * ramp_len;
        cruise_dist = (limited || 2 * ramp_len > s) ? 0 : s - 2 * ramp_len;
        cruise_dur = (limited || speed_v == 0) ? 0 : sat32((cruise_dist * 65536) / speed_v);
        decel_start = ramp_len + cruise_dist;
        ramp_time = ramp_dur[31:0];
        cruise_time = cruise_dur[31:0];
    endtask

    function automatic wide_t ramp_position(wide_t x, wide_t den);
        wide_t u, u2, u3, u4, a, b, p;
        u  = ((x << 32) / den) & 128'hFFFF_FFFF_FFFF_FFFF;
        u2 = (u * u) >> 32;
        u3 = (u2 * u) >> 32;
        u4 = (u3 * u) >> 32;
        a  = cubic_coeff * u3;
        b  = ramp_len * u4;
        if (a < b) return 0;
        p = sat32((a - b) >> 32);
        return (p > ramp_len) ? ramp_len : p;
    endfunction

    function automatic profile_t predict_profile(logic [31:0] t_in);
        profile_t r;
        wide_t t, t2, t3, tot;
        t = t_in;
        if (t < ramp_dur) begin
            r.position = ramp_position(t, ramp_dur);
            r.phase = PH_ACCEL;
        end else begin
            t2 = t - ramp_dur;
            if (t2 < cruise_dur) begin
                r.position = sat32(ramp_len + ((speed_v * t2) >> 16));
                r.phase = PH_CRUISE;
            end else begin
                t3 = t2 - cruise_dur;
                if (t3 < ramp_dur) begin
                    r.position = sat32(decel_start + ramp_len
                                       - ramp_position(ramp_dur - t3, ramp_dur));
                    r.phase = PH_DECEL;
                end else begin
                    r.position = sat32(decel_start + ramp_len);
                    r.phase = PH_DONE;
                end
            end
        end
        tot = 2 * ramp_dur + cruise_dur;
        r.total_time = sat32(tot);
        r.speed_limited = limited;
        return r;
    endfunction

    initial begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge i_clk) begin
        profile_t exp_p;
        if (!i_rst_n) begin
            accel_reg = 32'h1_0000;
            speed_reg = 32'h1_0000;
            dist_reg  = 32'h1_0000;
            derive_profile();
            profile_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_PEAK_ACCEL:    accel_reg = pwdata;
                    REG_SPEED_LIMIT:   speed_reg = pwdata;
                    REG_MOVE_DISTANCE: dist_reg = pwdata;
                    default: ;
                endcase
                derive_profile();
            end
            if (o_valid && !i_stall) begin
                if (profile_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result item at %0t", $realtime);
                end else begin
                    exp_p = profile_q.pop_front();
                    if (exp_p !== {o_position, o_phase, o_total_time, o_speed_limited}) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp pos %h ph %0d tot %h lim %b, got %h %0d %h %b",
                                     exp_p.position, exp_p.phase, exp_p.total_time,
                                     exp_p.speed_limited, o_position, o_phase, o_total_time,
                                     o_speed_limited);
                    end
                end
            end
            if (i_valid && !o_stall) profile_q.push_back(predict_profile(i_sample_time));
        end
        pending = profile_q.size();
    end
endmodule

// File: tb/sv/tb_s_curve_position_profile.sv
// Testbench top for the S-curve position profile: clock, reset, stimulus and verdict.
module tb_s_curve_position_profile;
    import scpp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 0;
    logic        o_stall;
    logic [31:0] i_sample_time = '0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [31:0] o_position, o_total_time;
    logic [1:0]  o_phase;
    logic        o_speed_limited;
    int          fail_count, pending;
    logic [31:0] ramp_time, cruise_time;
    bit          long_hold = 0;
    int          burst_left = 0;

    always #1 i_clk = ~i_clk;

    s_curve_position_profile dut (.*);

    s_curve_position_profile_chk chk (.*);

    initial begin
        #400us;
        $display("s_curve_position_profile test failed");
        $finish;
    end

    always begin
        int mode;
        mode = 0;
        repeat ($urandom_range(20, 120)) begin
            @(negedge i_clk);
            if (long_hold) begin
                i_stall <= 1;
                repeat (300) @(negedge i_clk);
                long_hold = 0;
            end else begin
                case (mode)
                    0: i_stall <= 0;
                    1: i_stall <= ($urandom_range(0, 9) < 3);
                    default: i_stall <= ($urandom_range(0, 9) < 7);
                endcase
            end
            if ($urandom_range(0, 40) == 0) mode = $urandom_range(0, 2);
        end
    end

    task automatic write_reg(logic [3:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel <= 1; pwrite <= 1; penable <= 0; paddr <= addr; pwdata <= data;
        @(negedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic send_sample(logic [31:0] t);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid <= 0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid <= 1;
        i_sample_time <= t;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 0;
        wait (pending == 0);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic run_phase(int n_rand, int tag);
        logic [63:0] tot, lim;
        logic [31:0] marks[10];
        tot = 64'(ramp_time) * 2 + cruise_time;
        marks = '{0, 32'hFFFF_FFFF, 1, ramp_time - 1, ramp_time, ramp_time + cruise_time - 1,
                  ramp_time + cruise_time, tot[31:0] - 1, tot[31:0], ramp_time >> 1};
        foreach (marks[i]) send_sample(marks[i]);
        lim = tot + (tot >> 3) + 16;
        if (lim > 64'hFFFF_FFFF) lim = 64'hFFFF_FFFF;
        for (int i = 0; i < n_rand; i++) begin
            if (tag == 6 && i == 10) long_hold = 1;
            if (tag == 7 && i == n_rand / 2) begin
                @(negedge i_clk);
                i_valid <= 0;
                wait (pending == 0);
            end
            if ($urandom_range(0, 3) == 0) send_sample($urandom);
            else send_sample($urandom_range(0, lim[31:0]));
        end
        drain();
    endtask

    task automatic set_profile(logic [31:0] a, logic [31:0] v, logic [31:0] s);
        write_reg({REG_PEAK_ACCEL, 2'b00}, a);
        write_reg({REG_SPEED_LIMIT, 2'b00}, v);
        write_reg({REG_MOVE_DISTANCE, 2'b00}, s);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        run_phase(60, 0);
        set_profile(1, 1, 1);
        run_phase(30, 1);
        set_profile(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_phase(60, 2);
        set_profile(0, 0, 32'hFFFF_FFFF);
        run_phase(60, 3);
        set_profile(1, 32'hFFFF_FFFF, 32'h0010_0000);
        run_phase(60, 4);
        set_profile($urandom_range(32'h100, 32'h0100_0000), $urandom, $urandom);
        write_reg(4'hC, $urandom);
        run_phase(70, 5);
        for (int k = 6; k < 11; k++) begin
            set_profile($urandom_range(32'h1000, 32'h0080_0000),
                        $urandom_range(32'h1000, 32'h0400_0000), $urandom);
            run_phase(70, k);
        end
        if (fail_count == 0) begin
            $display("s_curve_position_profile test passed");
        end else begin
            $display("s_curve_position_profile test failed");
        end
        $finish;
    end
endmodule
